// File: rtl/hst_pkg.sv
// Package for the handle slot table: payload structs, request and status codes,
// sequencer state encoding. No dependencies.
package hst_pkg;

  localparam int VALUE_W = 64;
  localparam int INDEX_W = 6;
  localparam int COUNT_W = 7;

  typedef enum logic [1:0] {
    REQ_PUSH   = 2'd0,
    REQ_GET    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    req_t                 req_type;
    logic [INDEX_W-1:0]   slot_index;
    logic [VALUE_W-1:0]   push_value;
  } hst_in_t;

  typedef struct packed {
    logic [INDEX_W-1:0]   result_index;
    logic [VALUE_W-1:0]   result_value;
    status_t              status;
    logic [COUNT_W-1:0]   live_count;
  } hst_out_t;

  typedef enum logic [2:0] {
    ST_INIT,   // clearing pass after reset
    ST_IDLE,
    ST_SCAN,   // free-slot search for a push
    ST_READ,   // slot read for get or remove
    ST_GET,
    ST_REM,
    ST_CLEAR,  // clear sweep
    ST_RESP
  } state_t;

endpackage

// File: rtl/hst_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module hst_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/hst_seq.sv
// Request sequencer for the handle slot table: FSM, count and hint registers,
// and all read-modify-write traffic to the slot RAM. Depends on hst_pkg.
module hst_seq
  import hst_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  hst_in_t                       in_data,
  output logic                          in_ready,
  input  logic [VALUE_W-1:0]            marker,
  output logic                          res_valid,
  input  logic                          res_ready,
  output hst_out_t                      res_data,
  output logic                          mem_we,
  output logic [$clog2(SLOTS)-1:0]      mem_waddr,
  output logic [VALUE_W-1:0]            mem_wdata,
  output logic                          mem_re,
  output logic [$clog2(SLOTS)-1:0]      mem_raddr,
  input  logic [VALUE_W-1:0]            mem_rdata
);

  localparam int AW = $clog2(SLOTS);
  localparam int HW = $clog2(SLOTS + 1);
  localparam int CW = (HW > COUNT_W) ? HW : COUNT_W;
  localparam logic [HW-1:0] SLOTS_H = HW'(SLOTS);
  localparam logic [AW-1:0] LAST_A  = AW'(SLOTS - 1);

  state_t           state_r,   state_nxt;
  hst_in_t          req_r,     req_nxt;
  logic [HW-1:0]    issue_r,   issue_nxt;
  logic [AW-1:0]    chk_r,     chk_nxt;
  logic             chk_v_r,   chk_v_nxt;
  logic [AW-1:0]    clr_r,     clr_nxt;
  logic [VALUE_W-1:0] clr_val_r, clr_val_nxt;
  logic [HW-1:0]    cnt_r,     cnt_nxt;
  logic [HW-1:0]    hint_r,    hint_nxt;
  hst_out_t         res_r,     res_nxt;

  logic             accept;
  logic             hit;
  logic             issue_lt;
  logic             clr_last;
  logic             in_range;
  logic [CW-1:0]    in_idx_ext;
  logic [CW-1:0]    req_idx_ext;
  logic [AW-1:0]    req_addr;

  // index and count as they appear on the result fields
  function automatic logic [INDEX_W-1:0] to_index(input logic [AW-1:0] a);
    logic [CW-1:0] e;
    e = CW'(a);
    return e[INDEX_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] to_count(input logic [HW-1:0] c);
    logic [CW-1:0] e;
    e = CW'(c);
    return e[COUNT_W-1:0];
  endfunction

  assign accept      = in_valid && in_ready;
  assign hit         = (mem_rdata == marker);
  assign issue_lt    = (issue_r < SLOTS_H);
  assign clr_last    = (clr_r == LAST_A);
  assign in_idx_ext  = CW'(in_data.slot_index);
  assign in_range    = (in_idx_ext < CW'(SLOTS));
  assign req_idx_ext = CW'(req_r.slot_index);
  assign req_addr    = req_idx_ext[AW-1:0];
  assign res_data    = res_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_data.req_type)
            REQ_PUSH:  state_nxt = ST_SCAN;
            REQ_CLEAR: state_nxt = ST_CLEAR;
            default:   state_nxt = in_range ? ST_READ : ST_RESP;
          endcase
        end
      end
      ST_READ: begin
        state_nxt = (req_r.req_type == REQ_GET) ? ST_GET : ST_REM;
      end
      ST_GET:  state_nxt = ST_RESP;
      ST_REM:  state_nxt = ST_RESP;
      ST_SCAN: begin
        if ((chk_v_r && hit) || (!chk_v_r && !issue_lt)) state_nxt = ST_RESP;
      end
      ST_CLEAR: begin
        if (clr_last) state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (res_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  // handshake and RAM control
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = req_addr;
    mem_wdata = marker;
    mem_re    = 1'b0;
    mem_raddr = req_addr;
    case (state_r)
      ST_IDLE: in_ready = rst_n;
      ST_READ: mem_re = 1'b1;
      ST_REM:  mem_we = 1'b1;
      ST_SCAN: begin
        mem_re    = issue_lt;
        mem_raddr = issue_r[AW-1:0];
        mem_we    = chk_v_r && hit;
        mem_waddr = chk_r;
        mem_wdata = req_r.push_value;
      end
      ST_INIT, ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = clr_val_r;
      end
      ST_RESP: res_valid = 1'b1;
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    req_nxt     = req_r;
    issue_nxt   = issue_r;
    chk_nxt     = chk_r;
    chk_v_nxt   = chk_v_r;
    clr_nxt     = clr_r;
    clr_val_nxt = clr_val_r;
    cnt_nxt     = cnt_r;
    hint_nxt    = hint_r;
    res_nxt     = res_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          req_nxt   = in_data;
          issue_nxt = hint_r;
          chk_v_nxt = 1'b0;
          clr_nxt   = '0;
          clr_val_nxt = marker;
          // default result: nothing found, marker as value
          res_nxt.result_index = '0;
          res_nxt.result_value = marker;
          res_nxt.status       = STAT_OK;
          res_nxt.live_count   = to_count(cnt_r);
          if (in_data.req_type != REQ_PUSH && in_data.req_type != REQ_CLEAR
              && !in_range) begin
            res_nxt.status = STAT_RANGE;
          end
        end
      end
      ST_GET: begin
        res_nxt.result_value = mem_rdata;
      end
      ST_REM: begin
        if (!hit && cnt_r != '0) cnt_nxt = cnt_r - 1'b1;
        if (HW'(req_addr) < hint_r) hint_nxt = HW'(req_addr);
        res_nxt.result_value = mem_rdata;
        res_nxt.live_count   = to_count(cnt_nxt);
      end
      ST_SCAN: begin
        // one read issued and one slot checked per cycle
        if (issue_lt) issue_nxt = issue_r + 1'b1;
        chk_nxt   = issue_r[AW-1:0];
        chk_v_nxt = issue_lt;
        if (chk_v_r && hit) begin
          if (req_r.push_value != marker && cnt_r < SLOTS_H) cnt_nxt = cnt_r + 1'b1;
          hint_nxt = HW'(chk_r) + 1'b1;
          res_nxt.result_index = to_index(chk_r);
          res_nxt.live_count   = to_count(cnt_nxt);
        end else if (!chk_v_r && !issue_lt) begin
          res_nxt.status = STAT_FULL;
        end
      end
      ST_INIT, ST_CLEAR: begin
        clr_nxt  = clr_r + 1'b1;
        cnt_nxt  = '0;
        hint_nxt = '0;
        res_nxt.live_count = '0;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_INIT;
      clr_r     <= '0;
      clr_val_r <= '0;
      cnt_r     <= '0;
      hint_r    <= '0;
      chk_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      clr_val_r <= clr_val_nxt;
      cnt_r     <= cnt_nxt;
      hint_r    <= hint_nxt;
      chk_v_r   <= chk_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    issue_r <= issue_nxt;
    chk_r   <= chk_nxt;
    res_r   <= res_nxt;
  end

endmodule

// File: rtl/handle_slot_table.sv
// Handle slot table: one request in, one result out. A push scans from the free
// hint to the first free slot (one slot checked per cycle, RAM read port). A new
// request can be taken in the cycle after the last result leaves the sequencer.
// After rst_n (synchronous, active low) a clearing pass writes zero to all SLOTS
// entries, one per cycle; in_ready stays low until the pass is done.
module handle_slot_table
  import hst_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hst_in_t             in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hst_out_t            out_data,
  input  logic                cfg_we,
  input  logic [VALUE_W-1:0]  cfg_wdata
);

  localparam int AW = $clog2(SLOTS);

  logic [VALUE_W-1:0] marker_r;
  logic               out_valid_r, out_valid_nxt;
  hst_out_t           out_data_r;
  logic               res_valid;
  logic               res_ready;
  hst_out_t           res_data;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [VALUE_W-1:0] mem_rdata;

  // empty marker register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r <= '0;
    end else if (cfg_we) begin
      marker_r <= cfg_wdata;
    end
  end

  hst_seq #(.SLOTS(SLOTS)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_ready  (in_ready),
    .marker    (marker_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  hst_ram #(.WIDTH(VALUE_W), .DEPTH(SLOTS)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register: takes a result whenever it is empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) out_valid_nxt = 1'b1;
    else if (out_ready)         out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_data_r <= res_data;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/hst_checker.sv
// Port-level checks for handle_slot_table, attached by bind.
// Depends on hst_pkg.
module hst_checker
  import hst_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input hst_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input hst_out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one request at a time: no transfer right after a transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  // clearing pass keeps input closed right after reset
  a_init_closed: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input open during clearing pass");

  // a full table reports slot zero
  a_full_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STAT_FULL |-> out_data.result_index == '0)
    else $error("full push reported a slot");

  // count never passes capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (SLOTS > 127) || (out_data.live_count <= 7'(SLOTS)))
    else $error("live count above capacity");

endmodule

bind handle_slot_table hst_checker #(.SLOTS(SLOTS)) u_hst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
